// ===== hw/rtl/int64_float64_converter_defines.svh =====
// ----------------------------------------------------------------------------
// int64_float64_converter_defines.svh
// Assertion macros shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef INT64_FLOAT64_CONVERTER_DEFINES_SVH
`define INT64_FLOAT64_CONVERTER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define I64F64_ASSERT_NEXT(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define I64F64_ASSERT_NOW(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/i64f64_pkg.sv =====
// ----------------------------------------------------------------------------
// i64f64_pkg
// Types and constants for the int64 / float64 converter.
// ----------------------------------------------------------------------------
package i64f64_pkg;

	// IEEE double layout
	localparam int ExpBits  = 11;
	localparam int MantBits = 52;
	localparam int WordBits = 64;

	localparam logic [ExpBits-1:0] ExpBias = 11'd1023;
	// exponent at which the mantissa LSB weighs one
	localparam logic [ExpBits-1:0] ExpUnit = 11'd1075;
	// exponent of 2^63: first saturating value
	localparam logic [ExpBits-1:0] ExpSat  = 11'd1086;
	localparam logic [ExpBits-1:0] ExpMax  = 11'h7FF;

	localparam logic [WordBits-1:0] IntMin = 64'h8000_0000_0000_0000;
	localparam logic [WordBits-1:0] IntMax = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic {
		CMD_INT_TO_DBL = 1'b0,
		CMD_DBL_TO_INT = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                command;
		logic [WordBits-1:0] operand;
	} in_beat_t;

	typedef struct packed {
		logic [WordBits-1:0] result;
	} out_beat_t;

endpackage

// ===== hw/rtl/i64f64_stream_if.sv =====
// ----------------------------------------------------------------------------
// i64f64_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface i64f64_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/int64_float64_converter.sv =====
// ----------------------------------------------------------------------------
// int64_float64_converter
// Converts between signed 64-bit integers and IEEE double bit patterns.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle while the output is not stalled and
// returns one result beat for each, in order. A beat passes an input
// register and then a result register before its result is offered; the
// throughput of one beat per clock, absent a stall, is set by the single-pass
// conversion logic (leading-zero shifter or exponent shifter) between those
// registers.
// Command 0 turns an integer into double bits with a truncated mantissa;
// command 1 turns double bits into an integer truncated toward zero, with
// NaN and magnitudes below one giving zero and 2^63 or more saturating.
// Backpressure on the output holds both registers and, once the input register is full, drops input ready.
// ----------------------------------------------------------------------------
`include "int64_float64_converter_defines.svh"

module int64_float64_converter (
	input  logic clk,
	input  logic arst_n,
	i64f64_stream_if.sink   ingress,
	i64f64_stream_if.source egress
);
	import i64f64_pkg::*;

	logic                valid_s1;
	cmd_t                command_s1;
	logic [WordBits-1:0] operand_s1;
	logic                valid_s2;
	logic [WordBits-1:0] result_s2;

	logic                adv_s2;
	logic                adv_s1;
	logic [WordBits-1:0] i2d_result;
	logic [WordBits-1:0] d2i_result;
	logic [WordBits-1:0] conv_result;

	// pipeline advance
	assign adv_s2        = !valid_s2 || egress.ready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign ingress.ready = adv_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= ingress.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1 && ingress.valid) begin
			command_s1 <= ingress.data.command;
			operand_s1 <= ingress.data.operand;
		end
	end

	// conversion datapaths
	i64f64_int_to_dbl u_int_to_dbl (
		.operand (operand_s1),
		.result  (i2d_result)
	);

	i64f64_dbl_to_int u_dbl_to_int (
		.operand (operand_s1),
		.result  (d2i_result)
	);

	always_comb begin
		case (command_s1)
			CMD_INT_TO_DBL: conv_result = i2d_result;
			CMD_DBL_TO_INT: conv_result = d2i_result;
			default:        conv_result = i2d_result;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= conv_result;
		end
	end

	assign egress.valid       = valid_s2;
	assign egress.data.result = result_s2;

	// checks
	`I64F64_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, ingress.valid && ingress.ready, valid_s1, "accepted beat lost before the input register")
	`I64F64_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv_s2, valid_s1 && $stable(operand_s1) && $stable(command_s1), "input register changed while stalled")
	`I64F64_ASSERT_NEXT(a_zero_int, clk, arst_n, valid_s1 && adv_s2 && command_s1 == CMD_INT_TO_DBL && operand_s1 == '0, valid_s2 && result_s2 == '0, "zero integer did not give +0.0")
	`I64F64_ASSERT_NEXT(a_nan_zero, clk, arst_n, valid_s1 && adv_s2 && command_s1 == CMD_DBL_TO_INT && operand_s1[62:52] == ExpMax && operand_s1[51:0] != '0, valid_s2 && result_s2 == '0, "NaN did not give zero")

endmodule

// ===== hw/rtl/i64f64_int_to_dbl.sv =====
// ----------------------------------------------------------------------------
// i64f64_int_to_dbl
// Signed 64-bit integer to double bits, mantissa truncated.
// ----------------------------------------------------------------------------
module i64f64_int_to_dbl (
	input  logic [i64f64_pkg::WordBits-1:0] operand,
	output logic [i64f64_pkg::WordBits-1:0] result
);
	import i64f64_pkg::*;

	logic                neg;
	logic [WordBits-1:0] mag;
	logic [WordBits-1:0] norm;
	logic [5:0]          lz;
	logic [ExpBits-1:0]  expo;

	// magnitude, then six-step log shifter for normalization
	always_comb begin
		neg  = operand[WordBits-1];
		mag  = neg ? (64'd0 - operand) : operand;
		norm = mag;
		lz   = '0;
		if (norm[63:32] == '0) begin
			norm  = norm << 32;
			lz[5] = 1'b1;
		end
		if (norm[63:48] == '0) begin
			norm  = norm << 16;
			lz[4] = 1'b1;
		end
		if (norm[63:56] == '0) begin
			norm  = norm << 8;
			lz[3] = 1'b1;
		end
		if (norm[63:60] == '0) begin
			norm  = norm << 4;
			lz[2] = 1'b1;
		end
		if (norm[63:62] == '0) begin
			norm  = norm << 2;
			lz[1] = 1'b1;
		end
		if (norm[63] == 1'b0) begin
			norm  = norm << 1;
			lz[0] = 1'b1;
		end
		expo = ExpSat - {5'd0, lz};
	end

	// hidden bit dropped, next 52 bits kept; zero maps to +0.0
	assign result = (operand == '0) ? '0 : {neg, expo, norm[WordBits-2 -: MantBits]};

endmodule

// ===== hw/rtl/i64f64_dbl_to_int.sv =====
// ----------------------------------------------------------------------------
// i64f64_dbl_to_int
// Double bits to signed 64-bit integer, truncated toward zero, saturating.
// ----------------------------------------------------------------------------
module i64f64_dbl_to_int (
	input  logic [i64f64_pkg::WordBits-1:0] operand,
	output logic [i64f64_pkg::WordBits-1:0] result
);
	import i64f64_pkg::*;

	logic                neg;
	logic [ExpBits-1:0]  expo;
	logic [MantBits-1:0] mant;
	logic [WordBits-1:0] sig;
	logic [WordBits-1:0] mag;
	logic [ExpBits-1:0]  rdist;
	logic [ExpBits-1:0]  ldist;

	always_comb begin
		neg   = operand[WordBits-1];
		expo  = operand[WordBits-2 -: ExpBits];
		mant  = operand[MantBits-1:0];
		sig   = {{(WordBits-MantBits-1){1'b0}}, 1'b1, mant};
		rdist = ExpUnit - expo;
		ldist = expo - ExpUnit;
		// right shift drops fraction bits, left shift stays below 2^63
		if (expo < ExpUnit) begin
			mag = sig >> rdist[5:0];
		end else begin
			mag = sig << ldist[3:0];
		end

		if (expo < ExpBias) begin
			// below one, zeros and subnormals
			result = '0;
		end else if (expo == ExpMax && mant != '0) begin
			// NaN
			result = '0;
		end else if (expo >= ExpSat) begin
			result = neg ? IntMin : IntMax;
		end else begin
			result = neg ? (64'd0 - mag) : mag;
		end
	end

endmodule
